// ===== rtl/lrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types and constants for the lidar return projection block.
// ----------------------------------------------------------------------------
package lrp_pkg;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_RETURN = 1'b1;

	localparam logic [2:0] CFG_BLANK = 3'd0;
	localparam logic [2:0] CFG_MAX   = 3'd1;
	localparam logic [2:0] CFG_SCALE = 3'd2;
	localparam logic [2:0] CFG_REF_X = 3'd3;
	localparam logic [2:0] CFG_REF_Y = 3'd4;
	localparam logic [2:0] CFG_REF_Z = 3'd5;

	localparam logic [15:0] BLANK_RESET = 16'd0;
	localparam logic [15:0] MAX_RESET   = 16'd2000;
	localparam logic [7:0]  SCALE_RESET = 8'd1;

	localparam logic [15:0] ANGLE_FULL    = 16'd36000;
	localparam logic [15:0] ANGLE_QUARTER = 16'd9000;
	localparam logic [15:0] ANGLE_HALF    = 16'd18000;
	localparam logic [15:0] ANGLE_3Q      = 16'd27000;

	// PI_Q30 = ANGLE_HALF * XR_Q + XR_R
	localparam logic [17:0] XR_Q = 18'd187403;
	localparam logic [12:0] XR_R = 13'd5426;

	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [14:0] SERIES_DIV [5] = '{15'd110, 15'd72, 15'd42, 15'd20, 15'd6};

	localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;

	typedef struct packed {
		logic [15:0] blank;
		logic [15:0] maxd;
		logic [7:0]  scale;
		logic [31:0] ref_x;
		logic [31:0] ref_y;
		logic [31:0] ref_z;
	} cfg_t;

	typedef struct packed {
		logic [15:0] cos_v;
		logic [15:0] sin_v;
		logic [15:0] rot;
		logic [12:0] doff;
	} cal_t;

	localparam int CAL_W = $bits(cal_t);

	typedef struct packed {
		logic        point;
		logic [15:0] bearing;
		logic [15:0] raw;
		logic [7:0]  inten;
		cal_t        cal;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_QUAD,
		ST_XR,
		ST_XR_DIV,
		ST_SQ,
		ST_T_MUL,
		ST_T_DIV,
		ST_SINE,
		ST_PROJ,
		ST_FIN,
		ST_DONE
	} state_t;

	function automatic logic signed [31:0] trunc_sat(input logic signed [63:0] v,
			input logic [4:0] sh);
		logic signed [63:0] bias;
		logic signed [63:0] w;
		logic signed [63:0] q;
		bias = (64'sd1 <<< sh) - 64'sd1;
		w = v[63] ? v + bias : v;
		q = w >>> sh;
		if (q > 64'(POS_MAX)) begin
			return POS_MAX;
		end else if (q < 64'(NEG_MAX)) begin
			return NEG_MAX;
		end
		return q[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lrp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output logic      [WIDTH-1:0]       rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/lrp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_div
// Iterative unsigned divider, 32 bit dividend, 15 bit divisor, 4 bits a cycle.
// ----------------------------------------------------------------------------
module lrp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [14:0] den,
	output logic             busy,
	output logic             done,
	output logic [31:0]      quo
);
	logic        busy_q;
	logic        done_q;
	logic [2:0]  cnt_q;
	logic [31:0] num_q;
	logic [14:0] rem_q;
	logic [14:0] den_q;
	logic [31:0] num_d;
	logic [14:0] rem_d;

	always_comb begin
		logic [15:0] r;
		num_d = num_q;
		rem_d = rem_q;
		for (int i = 0; i < 4; i++) begin
			r = {rem_d, num_d[31]};
			num_d = {num_d[30:0], 1'b0};
			if (r >= {1'b0, den_q}) begin
				r = r - {1'b0, den_q};
				num_d[0] = 1'b1;
			end
			rem_d = r[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= num_d;
			rem_q <= rem_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;
endmodule
`default_nettype wire

// ===== rtl/lrp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_front
// Accept requests, load calibration, cull returns, look up calibration.
// ----------------------------------------------------------------------------
module lrp_front #(
	parameter int LASERS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lrp_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          opcode,
	input  wire logic [4:0]    laser,
	input  wire logic [15:0]   bearing,
	input  wire logic [15:0]   distance,
	input  wire logic [7:0]    intensity,
	input  wire logic [15:0]   cos_vert,
	input  wire logic [15:0]   sin_vert,
	input  wire logic [15:0]   rot_offset,
	input  wire logic [12:0]   dist_offset,
	output logic               push,
	output lrp_pkg::job_t      push_job,
	input  wire logic          full
);
	localparam int AW = (LASERS > 1) ? $clog2(LASERS) : 1;
	localparam int XW = (AW > 5) ? AW : 5;

	logic          accept;
	logic          in_range;
	logic          keep;
	logic [XW-1:0] laser_x;
	logic [AW-1:0] addr;
	logic [lrp_pkg::CAL_W-1:0] rdata;
	lrp_pkg::cal_t wcal;

	logic          valid_s1;
	logic          point_s1;
	logic [15:0]   bearing_s1;
	logic [15:0]   raw_s1;
	logic [7:0]    inten_s1;

	assign in_stall = valid_s1 & full;
	assign accept   = in_valid & ~in_stall;
	assign push     = valid_s1 & ~full;
	assign laser_x  = XW'(laser);
	assign addr     = laser_x[AW-1:0];
	assign in_range = {27'd0, laser} < 32'(LASERS);
	assign keep     = in_range && (distance != 16'd0) && (distance >= cfg.blank)
		&& (distance <= cfg.maxd);
	assign wcal     = '{cos_v: cos_vert, sin_v: sin_vert, rot: rot_offset, doff: dist_offset};

	lrp_ram #(
		.WIDTH (lrp_pkg::CAL_W),
		.DEPTH (LASERS)
	) u_cal_ram (
		.clk   (clk),
		.we    (accept && (opcode == lrp_pkg::OP_LOAD) && in_range),
		.waddr (addr),
		.wdata (wcal),
		.re    (accept && (opcode == lrp_pkg::OP_RETURN) && keep),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			point_s1   <= (opcode == lrp_pkg::OP_RETURN) && keep;
			bearing_s1 <= bearing;
			raw_s1     <= distance;
			inten_s1   <= intensity;
		end
	end

	assign push_job = '{point: point_s1, bearing: bearing_s1, raw: raw_s1,
		inten: inten_s1, cal: lrp_pkg::cal_t'(rdata)};
endmodule
`default_nettype wire

// ===== rtl/lrp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_fifo
// Two entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module lrp_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lrp_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output lrp_pkg::job_t      pop_job,
	output logic               empty
);
	lrp_pkg::job_t ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign pop_job = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/lrp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_back
// Projection sequencer: azimuth sine and cosine by series, coordinates,
// bounding box, point count and the result register.
// ----------------------------------------------------------------------------
module lrp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lrp_pkg::cfg_t cfg,
	input  wire logic          empty,
	input  wire lrp_pkg::job_t pop_job,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               point_valid,
	output logic [31:0]        x,
	output logic [31:0]        y,
	output logic [31:0]        z,
	output logic [15:0]        point_intensity,
	output logic [31:0]        point_count,
	output logic [31:0]        min_x,
	output logic [31:0]        min_y,
	output logic [31:0]        min_z,
	output logic [31:0]        max_x,
	output logic [31:0]        max_y,
	output logic [31:0]        max_z
);
	lrp_pkg::state_t state_q;
	lrp_pkg::state_t state_d;

	lrp_pkg::job_t job_q;
	logic                pass_q;
	logic [2:0]          k_q;
	logic [15:0]         ang_q;
	logic [13:0]         r_q;
	logic                neg_q;
	logic [31:0]         xr_q;
	logic [31:0]         x2_q;
	logic [31:0]         t_q;
	logic signed [15:0]  sa_q;
	logic signed [15:0]  ca_q;
	logic signed [33:0]  hor_q;
	logic signed [33:0]  zp_q;
	logic signed [49:0]  mx_q;
	logic signed [49:0]  my_q;
	logic signed [31:0]  px_q;
	logic signed [31:0]  py_q;
	logic signed [31:0]  pz_q;
	logic [15:0]         pi_q;

	logic signed [31:0]  lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;
	logic [31:0]         cnt_q;

	logic                out_valid_q;
	logic                opoint_q;
	logic [31:0]         ox_q, oy_q, oz_q;
	logic [15:0]         oi_q;
	logic [31:0]         ocnt_q;
	logic signed [31:0]  omin_x_q, omin_y_q, omin_z_q, omax_x_q, omax_y_q, omax_z_q;

	logic        out_free;
	logic        load;
	logic        div_start;
	logic [31:0] div_num;
	logic [14:0] div_den;
	logic        div_busy;
	logic        div_done;
	logic [31:0] div_quo;

	logic signed [17:0] d_w;
	logic signed [17:0] a_w;
	logic [15:0]        qa_w;
	logic [63:0]        sq_w;
	logic [63:0]        tm_w;
	logic [63:0]        sm_w;
	logic [32:0]        rnd_w;
	logic [17:0]        mag_w;
	logic signed [15:0] trig_w;

	logic signed [31:0] nlo_x, nlo_y, nlo_z, nhi_x, nhi_y, nhi_z;
	logic [31:0]        ncnt;

	assign out_free = ~out_valid_q | ~out_stall;

	lrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrp_pkg::ST_IDLE: begin
				if (!empty) begin
					state_d = pop_job.point ? lrp_pkg::ST_ANGLE : lrp_pkg::ST_DONE;
				end
			end
			lrp_pkg::ST_ANGLE:  state_d = lrp_pkg::ST_QUAD;
			lrp_pkg::ST_QUAD:   state_d = lrp_pkg::ST_XR;
			lrp_pkg::ST_XR:     state_d = lrp_pkg::ST_XR_DIV;
			lrp_pkg::ST_XR_DIV: begin
				if (div_done) begin
					state_d = lrp_pkg::ST_SQ;
				end
			end
			lrp_pkg::ST_SQ:     state_d = lrp_pkg::ST_T_MUL;
			lrp_pkg::ST_T_MUL:  state_d = lrp_pkg::ST_T_DIV;
			lrp_pkg::ST_T_DIV: begin
				if (div_done) begin
					state_d = (k_q == 3'd4) ? lrp_pkg::ST_SINE : lrp_pkg::ST_T_MUL;
				end
			end
			lrp_pkg::ST_SINE:   state_d = pass_q ? lrp_pkg::ST_PROJ : lrp_pkg::ST_QUAD;
			lrp_pkg::ST_PROJ:   state_d = lrp_pkg::ST_FIN;
			lrp_pkg::ST_FIN:    state_d = lrp_pkg::ST_DONE;
			lrp_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = lrp_pkg::ST_IDLE;
				end
			end
			default: state_d = lrp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		div_start = 1'b0;
		div_num   = tm_w[61:30];
		div_den   = lrp_pkg::SERIES_DIV[k_q];
		unique case (state_q)
			lrp_pkg::ST_IDLE: pop = ~empty;
			lrp_pkg::ST_XR: begin
				div_start = 1'b1;
				div_num   = 32'(27'(r_q) * 27'(lrp_pkg::XR_R));
				div_den   = lrp_pkg::ANGLE_HALF[14:0];
			end
			lrp_pkg::ST_T_MUL: div_start = 1'b1;
			lrp_pkg::ST_DONE:  load = out_free;
			default: ;
		endcase
	end

	always_comb begin
		d_w = $signed({2'b00, job_q.raw}) + 18'($signed(job_q.cal.doff));
		a_w = $signed({2'b00, job_q.bearing}) + 18'($signed(job_q.cal.rot));
		if (a_w < 18'sd0) begin
			a_w = a_w + 18'sd36000;
		end
		if (a_w >= 18'sd36000) begin
			a_w = a_w - 18'sd36000;
		end
		if (a_w >= 18'sd36000) begin
			a_w = a_w - 18'sd36000;
		end
		if (!pass_q) begin
			qa_w = ang_q;
		end else if (ang_q >= lrp_pkg::ANGLE_3Q) begin
			qa_w = ang_q - lrp_pkg::ANGLE_3Q;
		end else begin
			qa_w = ang_q + lrp_pkg::ANGLE_QUARTER;
		end
		sq_w  = 64'(xr_q) * 64'(xr_q);
		tm_w  = 64'(x2_q) * 64'(t_q);
		sm_w  = 64'(xr_q) * 64'(t_q);
		rnd_w = 33'(sm_w[61:30]) + 33'd16384;
		mag_w = rnd_w[32:15];
		if (mag_w > 18'd32767) begin
			mag_w = 18'd32767;
		end
		trig_w = neg_q ? -$signed(mag_w[15:0]) : $signed(mag_w[15:0]);
	end

	always_comb begin
		nlo_x = lo_x_q;
		nlo_y = lo_y_q;
		nlo_z = lo_z_q;
		nhi_x = hi_x_q;
		nhi_y = hi_y_q;
		nhi_z = hi_z_q;
		ncnt  = cnt_q;
		if (job_q.point) begin
			if (px_q < lo_x_q) nlo_x = px_q;
			if (py_q < lo_y_q) nlo_y = py_q;
			if (pz_q < lo_z_q) nlo_z = pz_q;
			if (px_q > hi_x_q) nhi_x = px_q;
			if (py_q > hi_y_q) nhi_y = py_q;
			if (pz_q > hi_z_q) nhi_z = pz_q;
			if (cnt_q != 32'hffff_ffff) ncnt = cnt_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			lo_x_q      <= lrp_pkg::POS_MAX;
			lo_y_q      <= lrp_pkg::POS_MAX;
			lo_z_q      <= lrp_pkg::POS_MAX;
			hi_x_q      <= lrp_pkg::NEG_MAX;
			hi_y_q      <= lrp_pkg::NEG_MAX;
			hi_z_q      <= lrp_pkg::NEG_MAX;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
				lo_x_q      <= nlo_x;
				lo_y_q      <= nlo_y;
				lo_z_q      <= nlo_z;
				hi_x_q      <= nhi_x;
				hi_y_q      <= nhi_y;
				hi_z_q      <= nhi_z;
				cnt_q       <= ncnt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lrp_pkg::ST_IDLE: begin
				job_q <= pop_job;
				px_q  <= '0;
				py_q  <= '0;
				pz_q  <= '0;
				pi_q  <= '0;
			end
			lrp_pkg::ST_ANGLE: begin
				hor_q  <= d_w * $signed(job_q.cal.cos_v);
				zp_q   <= d_w * $signed(job_q.cal.sin_v);
				ang_q  <= a_w[15:0];
				pass_q <= 1'b0;
				pi_q   <= 16'(job_q.inten) * 16'(cfg.scale);
			end
			lrp_pkg::ST_QUAD: begin
				if (qa_w < lrp_pkg::ANGLE_QUARTER) begin
					r_q   <= qa_w[13:0];
					neg_q <= 1'b0;
				end else if (qa_w < lrp_pkg::ANGLE_HALF) begin
					r_q   <= 14'(lrp_pkg::ANGLE_HALF - qa_w);
					neg_q <= 1'b0;
				end else if (qa_w < lrp_pkg::ANGLE_3Q) begin
					r_q   <= 14'(qa_w - lrp_pkg::ANGLE_HALF);
					neg_q <= 1'b1;
				end else begin
					r_q   <= 14'(lrp_pkg::ANGLE_FULL - qa_w);
					neg_q <= 1'b1;
				end
			end
			lrp_pkg::ST_XR: xr_q <= 32'(r_q) * 32'(lrp_pkg::XR_Q);
			lrp_pkg::ST_XR_DIV: begin
				if (div_done) begin
					xr_q <= xr_q + div_quo;
				end
			end
			lrp_pkg::ST_SQ: begin
				x2_q <= sq_w[61:30];
				t_q  <= lrp_pkg::ONE_Q30;
				k_q  <= '0;
			end
			lrp_pkg::ST_T_DIV: begin
				if (div_done) begin
					t_q <= lrp_pkg::ONE_Q30 - div_quo;
					k_q <= k_q + 3'd1;
				end
			end
			lrp_pkg::ST_SINE: begin
				if (pass_q) begin
					ca_q <= trig_w;
				end else begin
					sa_q <= trig_w;
				end
				pass_q <= 1'b1;
			end
			lrp_pkg::ST_PROJ: begin
				mx_q <= hor_q * sa_q;
				my_q <= hor_q * ca_q;
			end
			lrp_pkg::ST_FIN: begin
				px_q <= lrp_pkg::trunc_sat(($signed(64'($signed(cfg.ref_x))) <<< 30)
					+ 64'(mx_q), 5'd30);
				py_q <= lrp_pkg::trunc_sat(($signed(64'($signed(cfg.ref_y))) <<< 30)
					+ 64'(my_q), 5'd30);
				pz_q <= lrp_pkg::trunc_sat(($signed(64'($signed(cfg.ref_z))) <<< 15)
					+ 64'(zp_q), 5'd15);
			end
			lrp_pkg::ST_DONE: begin
				if (load) begin
					opoint_q <= job_q.point;
					ox_q     <= px_q;
					oy_q     <= py_q;
					oz_q     <= pz_q;
					oi_q     <= pi_q;
					ocnt_q   <= ncnt;
					omin_x_q <= nlo_x;
					omin_y_q <= nlo_y;
					omin_z_q <= nlo_z;
					omax_x_q <= nhi_x;
					omax_y_q <= nhi_y;
					omax_z_q <= nhi_z;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign point_valid     = opoint_q;
	assign x               = ox_q;
	assign y               = oy_q;
	assign z               = oz_q;
	assign point_intensity = oi_q;
	assign point_count     = ocnt_q;
	assign min_x           = omin_x_q;
	assign min_y           = omin_y_q;
	assign min_z           = omin_z_q;
	assign max_x           = omax_x_q;
	assign max_y           = omax_y_q;
	assign max_z           = omax_z_q;

`ifndef SYNTHESIS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q >= $past(cnt_q)) else $error("point count went down");
	a_box_x: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && opoint_q) |-> (omin_x_q <= $signed(ox_q) && $signed(ox_q) <= omax_x_q))
		else $error("x outside bounding box");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == lrp_pkg::ST_IDLE && !empty))
		else $error("queue popped outside idle");
`endif
endmodule
`default_nettype wire

// ===== rtl/lidar_return_projection.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_return_projection
// Projects lidar returns from range and bearing to Cartesian points using a
// per-laser calibration table, with culling, bounding box and point count.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   input    | in_valid / in_stall   | opcode, laser, bearing, distance, ...
//   result   | out_valid / out_stall | point_valid, x, y, z, box, count
//   config   | cfg_we                | cfg_index, cfg_data
//
// A projected return runs the shared divider (4 quotient bits a cycle) once
// for the angle scale and five times for the series, for both sine and
// cosine. Loads and culled returns skip the divider.
// Reset clears config, box and count; the calibration RAM is not cleared.
// The front keeps accepting into a two entry queue while the back is busy or
// its result is stalled.
// ----------------------------------------------------------------------------
module lidar_return_projection #(
	parameter int LASERS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [4:0]  laser,
	input  wire logic [15:0] bearing,
	input  wire logic [15:0] distance,
	input  wire logic [7:0]  intensity,
	input  wire logic [15:0] cos_vert,
	input  wire logic [15:0] sin_vert,
	input  wire logic [15:0] rot_offset,
	input  wire logic [12:0] dist_offset,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             point_valid,
	output logic [31:0]      x,
	output logic [31:0]      y,
	output logic [31:0]      z,
	output logic [15:0]      point_intensity,
	output logic [31:0]      point_count,
	output logic [31:0]      min_x,
	output logic [31:0]      min_y,
	output logic [31:0]      min_z,
	output logic [31:0]      max_x,
	output logic [31:0]      max_y,
	output logic [31:0]      max_z
);
	lrp_pkg::cfg_t cfg_q;
	lrp_pkg::job_t push_job;
	lrp_pkg::job_t pop_job;
	logic push;
	logic full;
	logic pop;
	logic empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{blank: lrp_pkg::BLANK_RESET, maxd: lrp_pkg::MAX_RESET,
				scale: lrp_pkg::SCALE_RESET, ref_x: '0, ref_y: '0, ref_z: '0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrp_pkg::CFG_BLANK: cfg_q.blank <= cfg_data[15:0];
				lrp_pkg::CFG_MAX:   cfg_q.maxd  <= cfg_data[15:0];
				lrp_pkg::CFG_SCALE: cfg_q.scale <= cfg_data[7:0];
				lrp_pkg::CFG_REF_X: cfg_q.ref_x <= cfg_data;
				lrp_pkg::CFG_REF_Y: cfg_q.ref_y <= cfg_data;
				lrp_pkg::CFG_REF_Z: cfg_q.ref_z <= cfg_data;
				default: ;
			endcase
		end
	end

	lrp_front #(
		.LASERS (LASERS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.laser       (laser),
		.bearing     (bearing),
		.distance    (distance),
		.intensity   (intensity),
		.cos_vert    (cos_vert),
		.sin_vert    (sin_vert),
		.rot_offset  (rot_offset),
		.dist_offset (dist_offset),
		.push        (push),
		.push_job    (push_job),
		.full        (full)
	);

	lrp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	lrp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.empty           (empty),
		.pop_job         (pop_job),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.point_valid     (point_valid),
		.x               (x),
		.y               (y),
		.z               (z),
		.point_intensity (point_intensity),
		.point_count     (point_count),
		.min_x           (min_x),
		.min_y           (min_y),
		.min_z           (min_z),
		.max_x           (max_x),
		.max_y           (max_y),
		.max_z           (max_z)
	);
endmodule
`default_nettype wire
